// File: hw/rtl/aes_pkg.sv
// Shared AES types, S-box tables and round helper functions.
`default_nettype none
package aes_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;

    typedef logic [127:0] block_t;
    typedef logic [7:0]   byte_t;

    typedef enum logic [0:0] {
        REQ_ENCRYPT = 1'b0,
        REQ_DECRYPT = 1'b1
    } req_t;

    typedef enum logic [0:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } cfg_idx_t;

    localparam logic [7:0] REDUCE_POLY = 8'h1b;

    function automatic byte_t sbox_fwd(input byte_t x);
        byte_t r;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t sbox_inv(input byte_t x);
        byte_t r;
        case (x)
            8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
            8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
            8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
            8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
            8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
            8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
            8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
            8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
            8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
            8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
            8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
            8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
            8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
            8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
            8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
            8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
            8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
            8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
            8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
            8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
            8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
            8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
            8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
            8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
            8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
            8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
            8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
            8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
            8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
            8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
            8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
            8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
            8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
            8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
            8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
            8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
            8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
            8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
            8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
            8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
            8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
            8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
            8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
            8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
            8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
            8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
            8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
            8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
            8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
            8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
            8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
            8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
            8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
            8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
            8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
            8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
            8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
            8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
            8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
            8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
            8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
            8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
            8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
            8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t rcon(input logic [3:0] rnd);
        byte_t r;
        case (rnd)
            4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
            4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
            4'd9: r = 8'h1b; 4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t xt(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? REDUCE_POLY : 8'h00);
    endfunction

    // byte i of the block sits at bits 127-8i
    function automatic byte_t get_b(input block_t s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    // one key expansion round: rk(n) from rk(n-1)
    function automatic block_t next_key(input block_t k, input logic [3:0] rnd);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox_fwd(w3[23:16]) ^ rcon(rnd), sbox_fwd(w3[15:8]),
             sbox_fwd(w3[7:0]), sbox_fwd(w3[31:24])};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // inverse expansion round: rk(n-1) from rk(n)
    function automatic block_t prev_key(input block_t k, input logic [3:0] rnd);
        logic [31:0] w0, w1, w2, w3, t;
        w3 = k[31:0] ^ k[63:32]; w2 = k[63:32] ^ k[95:64];
        w1 = k[95:64] ^ k[127:96];
        t = {sbox_fwd(w3[23:16]) ^ rcon(rnd), sbox_fwd(w3[15:8]),
             sbox_fwd(w3[7:0]), sbox_fwd(w3[31:24])};
        w0 = k[127:96] ^ t;
        return {w0, w1, w2, w3};
    endfunction

    function automatic block_t enc_round(input block_t s, input logic last);
        block_t o;
        byte_t b [16];
        byte_t c0, c1, c2, c3;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                b[r + 4*c] = sbox_fwd(get_b(s, r + 4*((c + r) % 4)));
        for (int c = 0; c < 4; c++)
        begin
            c0 = b[4*c]; c1 = b[4*c+1]; c2 = b[4*c+2]; c3 = b[4*c+3];
            if (!last)
            begin
                b[4*c]   = xt(c0) ^ xt(c1) ^ c1 ^ c2 ^ c3;
                b[4*c+1] = c0 ^ xt(c1) ^ xt(c2) ^ c2 ^ c3;
                b[4*c+2] = c0 ^ c1 ^ xt(c2) ^ xt(c3) ^ c3;
                b[4*c+3] = xt(c0) ^ c0 ^ c1 ^ c2 ^ xt(c3);
            end
        end
        for (int i = 0; i < 16; i++)
            o[127 - 8*i -: 8] = b[i];
        return o;
    endfunction

    function automatic block_t inv_mix(input block_t s);
        block_t o;
        byte_t c [4];
        byte_t x2 [4];
        byte_t x4 [4];
        byte_t x8 [4];
        byte_t m9, mb, md, me;
        for (int col = 0; col < 4; col++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                c[j] = get_b(s, 4*col + j);
                x2[j] = xt(c[j]); x4[j] = xt(x2[j]); x8[j] = xt(x4[j]);
            end
            for (int r = 0; r < 4; r++)
            begin
                me = x8[r] ^ x4[r] ^ x2[r];
                mb = x8[(r+1)%4] ^ x2[(r+1)%4] ^ c[(r+1)%4];
                md = x8[(r+2)%4] ^ x4[(r+2)%4] ^ c[(r+2)%4];
                m9 = x8[(r+3)%4] ^ c[(r+3)%4];
                o[127 - 8*(4*col + r) -: 8] = me ^ mb ^ md ^ m9;
            end
        end
        return o;
    endfunction

    // inverse shift rows plus inverse sub bytes
    function automatic block_t inv_shsub(input block_t s);
        block_t o;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                o[127 - 8*(r + 4*((c + r) % 4)) -: 8] = sbox_inv(get_b(s, r + 4*c));
        return o;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aes_round_stage.sv
// One pipeline stage: one cipher round and one key schedule step.
`default_nettype none
module aes_round_stage (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  adv,
    input  wire                  in_valid,
    input  wire                  in_dec,
    input  wire aes_pkg::block_t in_state,
    input  wire aes_pkg::block_t in_key,
    input  wire [3:0]            enc_rnd,
    input  wire [3:0]            dec_rnd,
    output logic                 out_valid,
    output logic                 out_dec,
    output aes_pkg::block_t      out_state,
    output aes_pkg::block_t      out_key
);
    aes_pkg::block_t state_next;
    aes_pkg::block_t key_next;
    aes_pkg::block_t t;

    always_comb
    begin
        t = '0;
        if (in_dec == aes_pkg::REQ_DECRYPT)
        begin
            // key here is rk[dec_rnd+1]; derive rk[dec_rnd]
            key_next = aes_pkg::prev_key(in_key, dec_rnd + 4'd1);
            t = aes_pkg::inv_shsub(in_state) ^ key_next;
            state_next = (dec_rnd != 4'd0) ? aes_pkg::inv_mix(t) : t;
        end
        else
        begin
            key_next = aes_pkg::next_key(in_key, enc_rnd);
            state_next = aes_pkg::enc_round(in_state, enc_rnd == 4'd10) ^ key_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_dec   <= in_dec;
            out_state <= state_next;
            out_key   <= key_next;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/aes128_block_cipher.sv
// Top level: AES-128 encrypt/decrypt pipeline with key registers.
// Path from input transfer to result valid: entry stage, then ten round stages.
// Throughput: one block per cycle unless held; each round stage holds one block.
// A stalled output holds the whole pipeline; after reset or a key write the input
// is also held while the last round key is walked out.
// Reset clears stage valid bits and both key registers to zero.
`default_nettype none
module aes128_block_cipher #(
    parameter int ROUNDS = 10
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [0:0]   cfg_index,
    input  wire [63:0]  cfg_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         req_type,
    input  wire [63:0]  block_high,
    input  wire [63:0]  block_low,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);
    logic [63:0] key_high_reg, key_low_reg;
    logic adv;
    logic key_ready;

    logic            v   [ROUNDS+1];
    logic            d   [ROUNDS+1];
    aes_pkg::block_t st  [ROUNDS+1];
    aes_pkg::block_t kk  [ROUNDS+1];

    aes_pkg::block_t walk_reg;
    logic [3:0] walk_cnt_reg;

    assign adv = out_ready || !v[ROUNDS];
    assign key_ready = (walk_cnt_reg == 4'(ROUNDS));
    assign in_ready = adv && key_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aes_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                aes_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // decrypt starts from the last round key; walk it out serially after
    // each key write and hold input off until walk_reg holds it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_cnt_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            walk_cnt_reg <= 4'd0;
        end
        else if (walk_cnt_reg != 4'(ROUNDS))
        begin
            walk_cnt_reg <= walk_cnt_reg + 4'd1;
        end
    end
    always_ff @(posedge clk)
    begin
        if (walk_cnt_reg == 4'd0)
            walk_reg <= aes_pkg::next_key({key_high_reg, key_low_reg}, 4'd1);
        else if (walk_cnt_reg != 4'(ROUNDS))
            walk_reg <= aes_pkg::next_key(walk_reg, walk_cnt_reg + 4'd1);
    end

    // entry stage: initial add round key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v[0] <= 1'b0;
        else if (adv)
            v[0] <= in_valid && key_ready;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d[0] <= req_type;
            if (req_type == aes_pkg::REQ_DECRYPT)
            begin
                st[0] <= {block_high, block_low} ^ walk_reg;
                kk[0] <= walk_reg;
            end
            else
            begin
                st[0] <= {block_high, block_low} ^ {key_high_reg, key_low_reg};
                kk[0] <= {key_high_reg, key_low_reg};
            end
        end
    end

    for (genvar g = 1; g <= ROUNDS; g++)
    begin : g_rnd
        aes_round_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (v[g-1]),
            .in_dec    (d[g-1]),
            .in_state  (st[g-1]),
            .in_key    (kk[g-1]),
            .enc_rnd   (4'(g)),
            .dec_rnd   (4'(ROUNDS - g)),
            .out_valid (v[g]),
            .out_dec   (d[g]),
            .out_state (st[g]),
            .out_key   (kk[g])
        );
    end

    assign out_valid   = v[ROUNDS];
    assign result_high = st[ROUNDS][127:64];
    assign result_low  = st[ROUNDS][63:0];
endmodule
`default_nettype wire

// File: hw/rtl/aes_checker.sv
// Port-level checker for the cipher pipeline, bound to the top level.
`default_nettype none
module aes_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [63:0] result_high,
    input wire [63:0] result_low
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_high) && $stable(result_low))
        else $error("result changed under stall");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({result_high, result_low}))
        else $error("unknown result while valid");
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");
    a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid || rst_n)
        else $error("valid after reset");
endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_high(result_high), .result_low(result_low)
);
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the AES-128 ECB encrypt/decrypt pipeline.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 15;

    class cipher_scoreboard;
        aes_pkg::byte_t fwd_tab [256];
        aes_pkg::byte_t inv_tab [256];
        logic [63:0] key_hi, key_lo;
        aes_pkg::block_t expected_blocks [$];
        int mismatches;

        function new();
            aes_pkg::byte_t recip, v;
            key_hi = '0;
            key_lo = '0;
            mismatches = 0;
            // S-box = affine map of the multiplicative inverse in GF(2^8)
            for (int x = 0; x < 256; x++)
            begin
                recip = 8'h00;
                for (int y = 1; y < 256; y++)
                    if (x != 0 && gmul(8'(x), 8'(y)) == 8'h01)
                        recip = 8'(y);
                v = recip ^ {recip[6:0], recip[7]} ^ {recip[5:0], recip[7:6]}
                    ^ {recip[4:0], recip[7:5]} ^ {recip[3:0], recip[7:4]} ^ 8'h63;
                fwd_tab[x] = v;
                inv_tab[v] = 8'(x);
            end
        endfunction

        function aes_pkg::byte_t gmul(aes_pkg::byte_t a, aes_pkg::byte_t b);
            aes_pkg::byte_t acc;
            acc = 8'h00;
            for (int n = 0; n < 8; n++)
            begin
                if (b[n])
                    acc ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            end
            return acc;
        endfunction

        // byte i of a block sits at bits 127-8i; byte r+4c is row r, column c
        function aes_pkg::block_t sub_shift(aes_pkg::block_t s, bit inverse);
            aes_pkg::block_t t;
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    if (inverse)
                        t[127 - 8*(r + 4*((c + r) % 4)) -: 8] =
                            inv_tab[s[127 - 8*(r + 4*c) -: 8]];
                    else
                        t[127 - 8*(r + 4*c) -: 8] =
                            fwd_tab[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
            return t;
        endfunction

        function aes_pkg::block_t mix(aes_pkg::block_t s, bit inverse);
            aes_pkg::block_t t;
            aes_pkg::byte_t m [4];
            aes_pkg::byte_t acc;
            if (inverse)
                m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
            else
                m = '{8'h02, 8'h03, 8'h01, 8'h01};
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                begin
                    acc = 8'h00;
                    for (int j = 0; j < 4; j++)
                        acc ^= gmul(m[(j - r + 4) % 4], s[127 - 8*(4*c + j) -: 8]);
                    t[127 - 8*(4*c + r) -: 8] = acc;
                end
            return t;
        endfunction

        function aes_pkg::block_t crypt(aes_pkg::req_t op, aes_pkg::block_t blk);
            logic [31:0] w [44];
            logic [31:0] t;
            aes_pkg::block_t rk [11];
            aes_pkg::block_t s;
            aes_pkg::byte_t rc;
            rc = 8'h01;
            {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
            for (int i = 4; i < 44; i++)
            begin
                t = w[i-1];
                if (i % 4 == 0)
                begin
                    t = {fwd_tab[t[23:16]] ^ rc, fwd_tab[t[15:8]],
                         fwd_tab[t[7:0]], fwd_tab[t[31:24]]};
                    rc = gmul(rc, 8'h02);
                end
                w[i] = w[i-4] ^ t;
            end
            for (int n = 0; n < 11; n++)
                rk[n] = {w[4*n], w[4*n+1], w[4*n+2], w[4*n+3]};
            if (op == aes_pkg::REQ_ENCRYPT)
            begin
                s = blk ^ rk[0];
                for (int rnd = 1; rnd <= 10; rnd++)
                begin
                    s = sub_shift(s, 1'b0);
                    if (rnd < 10)
                        s = mix(s, 1'b0);
                    s ^= rk[rnd];
                end
            end
            else
            begin
                s = blk ^ rk[10];
                for (int rnd = 9; rnd >= 0; rnd--)
                begin
                    s = sub_shift(s, 1'b1);
                    s ^= rk[rnd];
                    if (rnd > 0)
                        s = mix(s, 1'b1);
                end
            end
            return s;
        endfunction

        function void set_key(aes_pkg::cfg_idx_t idx, logic [63:0] data);
            if (idx == aes_pkg::CFG_KEY_HIGH)
                key_hi = data;
            else
                key_lo = data;
        endfunction

        function void note_block(aes_pkg::req_t op, logic [63:0] hi, logic [63:0] lo);
            expected_blocks.insert(expected_blocks.size(), crypt(op, {hi, lo}));
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("mismatch %s: got %h expected %h", what, got, want);
        endtask

        task check_result(logic [63:0] hi, logic [63:0] lo);
            aes_pkg::block_t want;
            if (expected_blocks.size() == 0)
            begin
                report("unexpected result", hi, 64'h0);
                return;
            end
            want = expected_blocks.pop_front();
            if (hi !== want[127:64])
                report("result_high", hi, want[127:64]);
            if (lo !== want[63:0])
                report("result_low", lo, want[63:0]);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    int src_idle_pct;
    int sink_idle_pct;
    int idle_cycles;
    cipher_scoreboard sb;

    aes128_block_cipher dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
        .block_high(block_high), .block_low(block_low),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_high(result_high), .result_low(result_low)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= sink_idle_pct);

    // transfer monitor and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_block(aes_pkg::req_t'(req_type), block_high, block_low);
            if (out_valid && out_ready)
                sb.check_result(result_high, result_low);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_block(aes_pkg::req_t op, logic [63:0] hi, logic [63:0] lo);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= op;
        block_high <= hi;
        block_low  <= lo;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // hold off until every expected block has come back
    task automatic wait_empty();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_blocks.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_key(logic [63:0] hi, logic [63:0] lo);
        wait_empty();
        cfg_we    <= 1'b1;
        cfg_index <= aes_pkg::CFG_KEY_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= aes_pkg::CFG_KEY_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_key(aes_pkg::CFG_KEY_HIGH, hi);
        sb.set_key(aes_pkg::CFG_KEY_LOW, lo);
    endtask

    task automatic random_blocks(int count);
        aes_pkg::req_t op;
        for (int i = 0; i < count; i++)
        begin
            op = $urandom_range(1) ? aes_pkg::REQ_DECRYPT : aes_pkg::REQ_ENCRYPT;
            send_block(op, {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    initial
    begin
        sb = new();
        src_idle_pct  = 17;
        sink_idle_pct = 68;
        idle_cycles   = 0;
        rst_n      = 1'b0;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = aes_pkg::CFG_KEY_HIGH;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = aes_pkg::REQ_ENCRYPT;
        block_high = '0;
        block_low  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key of all zeros, extreme blocks both ways
        send_block(aes_pkg::REQ_ENCRYPT, '0, '0);
        send_block(aes_pkg::REQ_DECRYPT, '0, '0);
        send_block(aes_pkg::REQ_ENCRYPT, '1, '1);
        send_block(aes_pkg::REQ_DECRYPT, '1, '1);
        // standard known-answer vector
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(aes_pkg::REQ_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(aes_pkg::REQ_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(aes_pkg::REQ_ENCRYPT, '0, '1);
        send_block(aes_pkg::REQ_DECRYPT, '1, '0);
        load_key('1, '1);
        send_block(aes_pkg::REQ_ENCRYPT, '0, '0);
        send_block(aes_pkg::REQ_DECRYPT, '1, '1);
        send_block(aes_pkg::REQ_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
        // key change takes effect on the very next block
        load_key('1, '0);
        send_block(aes_pkg::REQ_ENCRYPT, '0, '0);
        load_key('0, '1);
        send_block(aes_pkg::REQ_DECRYPT, '0, '0);

        load_key({$urandom, $urandom}, {$urandom, $urandom});
        random_blocks(165);
        src_idle_pct  = 68;
        sink_idle_pct = 17;
        load_key({$urandom, $urandom}, {$urandom, $urandom});
        random_blocks(165);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        load_key({$urandom, $urandom}, {$urandom, $urandom});
        random_blocks(170);

        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// File: aes128_block_cipher.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_round_stage.sv
hw/rtl/aes128_block_cipher.sv
hw/rtl/aes_checker.sv
sim/testbench.sv
